>>> src/arcp_pkg.sv
// Shared constants and types of the archive record chain parser.
package arcp_pkg;

  localparam int OFFSET_BITS_DEFAULT = 40;
  localparam int CFG_W = 40;
  localparam int BASE_W = 40;
  localparam int MAXM_W = 17;
  localparam logic [MAXM_W-1:0] MAXM_RESET = 17'd100000;
  localparam logic [MAXM_W-1:0] COUNT_MAX = 17'h1FFFF;
  localparam int FIXED_LEN = 13;
  localparam int RES_FIXED_BITS = 118;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_BASE_OFFSET = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_MEMBERS = 2'd1;

  localparam logic [1:0] KIND_NAME_CHAR = 2'd0;
  localparam logic [1:0] KIND_MEMBER = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [3:0] ERR_SIGNATURE = 4'd0;
  localparam logic [3:0] ERR_NO_MEMBERS = 4'd1;
  localparam logic [3:0] ERR_TRUNCATED = 4'd2;
  localparam logic [3:0] ERR_NAME_CHAR = 4'd3;
  localparam logic [3:0] ERR_PATH = 4'd4;
  localparam logic [3:0] ERR_EXTRA_CHAR = 4'd5;
  localparam logic [3:0] ERR_NEG_SIZE = 4'd6;
  localparam logic [3:0] ERR_DIR_VOLUME = 4'd7;
  localparam logic [3:0] ERR_EMPTY_SIZE = 4'd8;
  localparam logic [3:0] ERR_STREAM_PREFIX = 4'd9;
  localparam logic [3:0] ERR_TOO_MANY = 4'd10;

  typedef struct packed {
    logic valid0;
    logic valid1;
  } push_t;

endpackage

>>> src/arcp_parser.sv
// Parse state registers and the per-byte step logic of the record chain parser.
module arcp_parser #(
  parameter int OFFSET_BITS = arcp_pkg::OFFSET_BITS_DEFAULT,
  parameter int RES_W = arcp_pkg::RES_FIXED_BITS + 3 * OFFSET_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  logic [7:0] data_byte,
  input  logic first_byte,
  input  logic final_byte,
  input  logic cfg_we,
  input  logic [arcp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [arcp_pkg::CFG_W-1:0] cfg_data,
  output arcp_pkg::push_t push,
  output logic [RES_W-1:0] res0,
  output logic [RES_W-1:0] res1
);
  import arcp_pkg::*;

  typedef enum logic [8:0] {
    PH_SIG      = 9'b000000001,
    PH_RECSTART = 9'b000000010,
    PH_NAME     = 9'b000000100,
    PH_EXTLEN   = 9'b000001000,
    PH_EXT      = 9'b000010000,
    PH_FIXED    = 9'b000100000,
    PH_PAYLOAD  = 9'b001000000,
    PH_DONE     = 9'b010000000,
    PH_ERR      = 9'b100000000
  } phase_t;

  localparam int OB = OFFSET_BITS;

  phase_t phase, phase_next, e_phase;
  logic [OB-1:0] position, position_next, e_pos, pos_p1;
  logic [7:0] field_count, field_count_next, e_fc, fc_dec;
  logic [1:0] comp_len, comp_len_next, e_len;
  logic all_dots, all_dots_next, e_dots;
  logic [OB-1:0] record_start, record_start_next, e_rs;
  logic [7:0] fixed [FIXED_LEN];
  logic [7:0] fixed_next [FIXED_LEN];
  logic [30:0] skip, skip_next;
  logic [MAXM_W-1:0] member_count, member_count_next, e_mc;
  logic pend_bad, pend_bad_next, pend_path, pend_path_next;
  logic [BASE_W-1:0] base_offset;
  logic [MAXM_W-1:0] max_members;

  logic [OB-1:0] base_ext, ds;
  logic [7:0] mch;
  logic bad_char, comp_bad_cur, rec_now, member_now, ok;
  logic [31:0] unc, comp;
  logic m_valid, e_valid;
  logic [1:0] m_kind;
  logic [6:0] m_char;
  logic [OB-1:0] m_hoff, m_doff, m_asize, hdiff;
  logic [9:0] m_hsize;
  logic [30:0] m_comp, m_unc;
  logic m_empty;
  logic [31:0] m_dos;
  logic [3:0] e_code;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    case (idx)
      2'd0: sig_byte = 8'h4B;
      2'd1: sig_byte = 8'h4A;
      2'd2: sig_byte = 8'h64;
      default: sig_byte = 8'h00;
    endcase
  endfunction

  assign base_ext = OB'(base_offset);

  always_comb begin
    e_phase = first_byte ? PH_SIG : phase;
    e_pos = first_byte ? '0 : position;
    e_fc = first_byte ? '0 : field_count;
    e_len = first_byte ? '0 : comp_len;
    e_dots = first_byte ? 1'b1 : all_dots;
    e_rs = first_byte ? '0 : record_start;
    e_mc = first_byte ? '0 : member_count;
    pos_p1 = e_pos + OB'(1);
    fc_dec = e_fc - 8'd1;

    phase_next = e_phase;
    position_next = e_pos;
    field_count_next = e_fc;
    comp_len_next = e_len;
    all_dots_next = e_dots;
    record_start_next = e_rs;
    fixed_next = fixed;
    skip_next = skip;
    member_count_next = e_mc;
    pend_bad_next = first_byte ? 1'b0 : pend_bad;
    pend_path_next = first_byte ? 1'b0 : pend_path;

    m_valid = 1'b0;
    m_kind = KIND_NAME_CHAR;
    m_char = '0;
    m_hoff = '0;
    m_hsize = '0;
    m_doff = '0;
    m_comp = '0;
    m_unc = '0;
    m_empty = 1'b0;
    m_dos = '0;
    m_asize = '0;
    e_valid = 1'b0;
    e_code = ERR_SIGNATURE;
    rec_now = 1'b0;
    member_now = 1'b0;
    ds = '0;
    mch = (data_byte == 8'h5C) ? 8'h2F : data_byte;
    bad_char = (data_byte < 8'h20) || (data_byte > 8'h7E);
    comp_bad_cur = (e_len == 2'd0) || (e_dots && e_len <= 2'd2);
    ok = 1'b0;

    if (e_phase != PH_DONE && e_phase != PH_ERR) begin
      position_next = pos_p1;
      if (e_phase == PH_SIG) begin
        if (e_fc < 8'd4) begin
          if (data_byte != sig_byte(e_fc[1:0])) pend_bad_next = 1'b1;
          field_count_next = e_fc + 8'd1;
        end else if (pend_bad_next) begin
          e_valid = 1'b1;
          e_code = ERR_SIGNATURE;
        end else if (data_byte == 8'd0) begin
          e_valid = 1'b1;
          e_code = ERR_NO_MEMBERS;
        end else begin
          rec_now = 1'b1;
        end
      end else if (e_phase == PH_RECSTART) begin
        rec_now = 1'b1;
      end else if (e_phase == PH_NAME) begin
        m_valid = 1'b1;
        m_kind = KIND_NAME_CHAR;
        m_char = mch[6:0];
        if (bad_char) pend_bad_next = 1'b1;
        if (mch == 8'h2F) begin
          if (comp_bad_cur) pend_path_next = 1'b1;
          comp_len_next = 2'd0;
          all_dots_next = 1'b1;
        end else begin
          if (e_len < 2'd3) comp_len_next = e_len + 2'd1;
          if (mch != 8'h2E) all_dots_next = 1'b0;
        end
        field_count_next = fc_dec;
        if (fc_dec == 8'd0) begin
          if (comp_len_next != 2'd0 && all_dots_next && comp_len_next <= 2'd2) begin
            pend_path_next = 1'b1;
          end
          if (pend_bad_next) begin
            e_valid = 1'b1;
            e_code = ERR_NAME_CHAR;
          end else if (pend_path_next) begin
            e_valid = 1'b1;
            e_code = ERR_PATH;
          end else begin
            phase_next = PH_EXTLEN;
          end
        end
      end else if (e_phase == PH_EXTLEN) begin
        pend_bad_next = 1'b0;
        field_count_next = data_byte;
        phase_next = (data_byte == 8'd0) ? PH_FIXED : PH_EXT;
      end else if (e_phase == PH_EXT) begin
        if (bad_char) pend_bad_next = 1'b1;
        field_count_next = fc_dec;
        if (fc_dec == 8'd0) begin
          if (pend_bad_next) begin
            e_valid = 1'b1;
            e_code = ERR_EXTRA_CHAR;
          end else begin
            phase_next = PH_FIXED;
          end
        end
      end else if (e_phase == PH_FIXED) begin
        if (e_fc < 8'(FIXED_LEN)) fixed_next[e_fc[3:0]] = data_byte;
        field_count_next = e_fc + 8'd1;
      end else if (e_phase == PH_PAYLOAD) begin
        if (e_fc < 8'd4) begin
          ok = (e_fc == 8'd0 && data_byte == 8'hB5) || (e_fc == 8'd1 && data_byte == 8'h9C) ||
               (e_fc == 8'd2 && data_byte <= 8'd1) || (e_fc == 8'd3 && data_byte == 8'hFF);
          if (!ok) pend_bad_next = 1'b1;
          field_count_next = e_fc + 8'd1;
        end
        skip_next = skip - 31'd1;
      end
    end

    unc = {fixed_next[8], fixed_next[7], fixed_next[6], fixed_next[5]};
    comp = {fixed_next[12], fixed_next[11], fixed_next[10], fixed_next[9]};

    if (e_phase == PH_FIXED && field_count_next >= 8'(FIXED_LEN)) begin
      if (unc[31] || comp[31]) begin
        e_valid = 1'b1;
        e_code = ERR_NEG_SIZE;
      end else if ((fixed_next[0] & 8'h18) != 8'd0) begin
        e_valid = 1'b1;
        e_code = ERR_DIR_VOLUME;
      end else if (comp == 32'd0 && unc != 32'd0) begin
        e_valid = 1'b1;
        e_code = ERR_EMPTY_SIZE;
      end else if (comp == 32'd0) begin
        member_now = 1'b1;
        ds = pos_p1;
      end else begin
        skip_next = comp[30:0];
        field_count_next = 8'd0;
        pend_bad_next = 1'b0;
        phase_next = PH_PAYLOAD;
      end
    end

    if (e_phase == PH_PAYLOAD && skip_next == 31'd0) begin
      if (pend_bad_next || comp < 32'd4) begin
        e_valid = 1'b1;
        e_code = ERR_STREAM_PREFIX;
      end else begin
        member_now = 1'b1;
        ds = pos_p1 - OB'(comp);
      end
    end

    if (rec_now) begin
      if (e_mc > max_members) begin
        e_valid = 1'b1;
        e_code = ERR_TOO_MANY;
      end else if (data_byte == 8'd0) begin
        phase_next = PH_DONE;
        m_valid = 1'b1;
        m_kind = KIND_COMPLETE;
        m_asize = pos_p1;
      end else begin
        record_start_next = e_pos;
        field_count_next = data_byte;
        comp_len_next = 2'd0;
        all_dots_next = 1'b1;
        pend_bad_next = 1'b0;
        pend_path_next = 1'b0;
        phase_next = PH_NAME;
      end
    end

    hdiff = ds - e_rs;
    if (member_now) begin
      m_valid = 1'b1;
      m_kind = KIND_MEMBER;
      m_hoff = base_ext + e_rs;
      m_hsize = hdiff[9:0];
      m_doff = base_ext + ds;
      m_comp = comp[30:0];
      m_unc = unc[30:0];
      m_empty = (comp == 32'd0);
      m_dos = {fixed_next[2], fixed_next[1], fixed_next[4], fixed_next[3]};
      if (e_mc < COUNT_MAX) member_count_next = e_mc + MAXM_W'(1);
      phase_next = PH_RECSTART;
    end

    if (e_valid) phase_next = PH_ERR;

    if (e_phase != PH_DONE && e_phase != PH_ERR && final_byte &&
        phase_next != PH_DONE && phase_next != PH_ERR) begin
      e_valid = 1'b1;
      if (phase_next == PH_RECSTART && member_count_next > max_members) begin
        e_code = ERR_TOO_MANY;
      end else begin
        e_code = ERR_TRUNCATED;
      end
      phase_next = PH_ERR;
    end
  end

  always_comb begin
    push.valid0 = step && (m_valid || e_valid);
    push.valid1 = step && m_valid && e_valid;
    res1 = {KIND_ERROR, 7'd0, OB'(0), 10'd0, OB'(0), 31'd0, 31'd0, 1'b0, 32'd0, OB'(0),
            e_code};
    if (m_valid) begin
      res0 = {m_kind, m_char, m_hoff, m_hsize, m_doff, m_comp, m_unc, m_empty, m_dos,
              m_asize, 4'd0};
    end else begin
      res0 = res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SIG;
      position <= '0;
      field_count <= '0;
      comp_len <= '0;
      all_dots <= 1'b1;
      record_start <= '0;
      skip <= '0;
      member_count <= '0;
      pend_bad <= 1'b0;
      pend_path <= 1'b0;
      base_offset <= '0;
      max_members <= MAXM_RESET;
    end else begin
      if (step) begin
        phase <= phase_next;
        position <= position_next;
        field_count <= field_count_next;
        comp_len <= comp_len_next;
        all_dots <= all_dots_next;
        record_start <= record_start_next;
        skip <= skip_next;
        member_count <= member_count_next;
        pend_bad <= pend_bad_next;
        pend_path <= pend_path_next;
      end
      if (cfg_we && cfg_index == REG_BASE_OFFSET) base_offset <= cfg_data[BASE_W-1:0];
      if (cfg_we && cfg_index == REG_MAX_MEMBERS) max_members <= cfg_data[MAXM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (step) fixed <= fixed_next;
  end

endmodule

>>> src/arcp_result_fifo.sv
// Four-entry result queue that takes up to two results per cycle and gives one.
module arcp_result_fifo #(
  parameter int W = 8
) (
  input  logic clk,
  input  logic rst,
  input  arcp_pkg::push_t push,
  input  logic [W-1:0] din0,
  input  logic [W-1:0] din1,
  input  logic pop,
  output logic [W-1:0] dout,
  output logic not_empty,
  output logic [2:0] level
);
  import arcp_pkg::*;

  logic [W-1:0] mem [4];
  logic [1:0] wp, rp, wp1;
  logic [2:0] level_next;

  assign wp1 = wp + 2'd1;
  assign dout = mem[rp];
  assign not_empty = (level != 3'd0);
  assign level_next = level + {2'd0, push.valid0} + {2'd0, push.valid1} -
                      {2'd0, pop && not_empty};

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      level <= '0;
    end else begin
      wp <= wp + {1'b0, push.valid0} + {1'b0, push.valid1};
      if (pop && not_empty) rp <= rp + 2'd1;
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid0) mem[wp] <= din0;
    if (push.valid1) mem[wp1] <= din1;
  end

endmodule

>>> src/archive_record_chain_parser_core.sv
// Top level of the archive record chain parser: parse step and result queue.
// The block takes one archive byte per cycle and accepts a new byte in every
// cycle while its four-entry result queue has room for two more results; a byte
// yields zero, one or two results (a name character or member descriptor may be
// followed by an error), which leave one per cycle. The parse state updates in the
// cycle a byte is accepted, so a result is in the result queue in the cycle after its byte.
// After an error or the terminator, bytes are dropped until first_byte is set.
module archive_record_chain_parser_core #(
  parameter int OFFSET_BITS = arcp_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] data_byte,
  input  logic first_byte,
  input  logic final_byte,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] kind,
  output logic [6:0] name_char,
  output logic [OFFSET_BITS-1:0] rec_offset,
  output logic [9:0] rec_hdr_len,
  output logic [OFFSET_BITS-1:0] payload_offset,
  output logic [30:0] stored_len,
  output logic [30:0] plain_len,
  output logic is_empty,
  output logic [31:0] dos_timestamp,
  output logic [OFFSET_BITS-1:0] arc_total,
  output logic [3:0] error_code,
  input  logic cfg_we,
  input  logic [arcp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [arcp_pkg::CFG_W-1:0] cfg_data
);
  import arcp_pkg::*;

  localparam int RES_W = RES_FIXED_BITS + 3 * OFFSET_BITS;

  push_t push;
  logic [RES_W-1:0] res0, res1, head;
  logic [2:0] level;
  logic step;

  assign in_ready = (level <= 3'd2);
  assign step = in_valid && in_ready;

  arcp_parser #(
    .OFFSET_BITS(OFFSET_BITS),
    .RES_W(RES_W)
  ) u_parser (
    .clk(clk),
    .rst(rst),
    .step(step),
    .data_byte(data_byte),
    .first_byte(first_byte),
    .final_byte(final_byte),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .res0(res0),
    .res1(res1)
  );

  arcp_result_fifo #(
    .W(RES_W)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .din0(res0),
    .din1(res1),
    .pop(out_ready),
    .dout(head),
    .not_empty(out_valid),
    .level(level)
  );

  assign {kind, name_char, rec_offset, rec_hdr_len, payload_offset, stored_len,
          plain_len, is_empty, dos_timestamp, arc_total, error_code} = head;

  a_level_bound: assert property (@(posedge clk) disable iff (rst) level <= 3'd4)
    else $error("result queue level out of range");
  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push.valid1 |-> push.valid0)
    else $error("second result pushed without a first");
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> level >= 3'd3)
    else $error("input stalled while queue has room");
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("results present after reset");

endmodule

>>> sim/tb_archive_record_chain_parser_core.sv
// Testbench for the archive record chain parser: directed table, random archives, self-check.
module tb_archive_record_chain_parser_core;
  import arcp_pkg::*;

  typedef enum logic [3:0] {
    PH_SIG, PH_REC, PH_NAME, PH_EXTLEN, PH_EXT, PH_FIXED, PH_PAYLOAD, PH_DONE, PH_ERR
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       fin;
  } arc_byte_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  name_char;
    logic [39:0] rec_offset;
    logic [9:0]  rec_hdr_len;
    logic [39:0] payload_offset;
    logic [30:0] stored_len;
    logic [30:0] plain_len;
    logic        is_empty;
    logic [31:0] dos_timestamp;
    logic [39:0] arc_total;
    logic [3:0]  error_code;
  } parse_result_t;

  typedef struct {
    arc_byte_t   b;
    bit          chk;
    logic [1:0]  kind;
    logic [39:0] val;
  } dir_row_t;

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] data_byte = '0;
  logic first_byte = 1'b0;
  logic final_byte = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] kind;
  logic [6:0] name_char;
  logic [39:0] rec_offset;
  logic [9:0] rec_hdr_len;
  logic [39:0] payload_offset;
  logic [30:0] stored_len;
  logic [30:0] plain_len;
  logic is_empty;
  logic [31:0] dos_timestamp;
  logic [39:0] arc_total;
  logic [3:0] error_code;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_BASE_OFFSET;
  logic [CFG_W-1:0] cfg_data = '0;

  archive_record_chain_parser_core i_dut (.*);

  always #5 clk = ~clk;

  parse_result_t expected_q[$];
  arc_byte_t arc_q[$];
  dir_row_t dir_tab[$];
  int err_cnt = 0;
  int items_sent = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  int idle_cycles = 0;

  logic [39:0] base_off;
  logic [16:0] max_mem;
  parse_phase_t ph;
  logic [39:0] pos;
  int fcount;
  int clen;
  bit cdots;
  logic [39:0] rec_start;
  logic [7:0] fx[13];
  logic [31:0] skip_left;
  int mcount;
  bit pend_bad;
  bit pend_path;

  function automatic void clear_parse();
    ph = PH_SIG;
    pos = '0;
    fcount = 0;
    clen = 0;
    cdots = 1'b1;
    rec_start = '0;
    foreach (fx[i]) fx[i] = '0;
    skip_left = '0;
    mcount = 0;
    pend_bad = 1'b0;
    pend_path = 1'b0;
  endfunction

  function automatic void add_result(logic [1:0] k, int slot, logic [39:0] v);
    parse_result_t r;
    r = '0;
    r.kind = k;
    if (slot == 1) r.name_char = v[6:0];
    else if (slot == 9) r.arc_total = v;
    else if (slot == 10) r.error_code = v[3:0];
    expected_q.push_back(r);
  endfunction

  function automatic void fail_parse(logic [3:0] code);
    ph = PH_ERR;
    add_result(KIND_ERROR, 10, {36'd0, code});
  endfunction

  function automatic logic [31:0] le32(int i);
    return {fx[i+3], fx[i+2], fx[i+1], fx[i]};
  endfunction

  function automatic bit comp_bad();
    return clen == 0 || (cdots && clen <= 2);
  endfunction

  function automatic void add_member(logic [39:0] data_start);
    parse_result_t r;
    logic [31:0] comp;
    logic [31:0] unc;
    logic [39:0] hsize;
    comp = le32(9);
    unc = le32(5);
    hsize = data_start - rec_start;
    r = '0;
    r.kind = KIND_MEMBER;
    r.rec_offset = base_off + rec_start;
    r.rec_hdr_len = hsize[9:0];
    r.payload_offset = base_off + data_start;
    r.stored_len = comp[30:0];
    r.plain_len = unc[30:0];
    r.is_empty = (comp == 0);
    r.dos_timestamp = {fx[2], fx[1], fx[4], fx[3]};
    expected_q.push_back(r);
    if (mcount < 131071) mcount++;
    ph = PH_REC;
  endfunction

  function automatic void parse_byte(arc_byte_t it);
    logic [7:0] b;
    logic [7:0] m;
    logic [39:0] p;
    logic [31:0] unc;
    logic [31:0] comp;
    bit ok;
    b = it.data;
    if (it.first) clear_parse();
    if (ph == PH_DONE || ph == PH_ERR) return;
    p = pos;
    pos = pos + 40'd1;
    if (ph == PH_SIG) begin
      if (fcount < 4) begin
        case (fcount)
          0: ok = (b == 8'h4B);
          1: ok = (b == 8'h4A);
          2: ok = (b == 8'h64);
          default: ok = (b == 8'h00);
        endcase
        if (!ok) pend_bad = 1'b1;
        fcount++;
      end else if (pend_bad) begin
        fail_parse(ERR_SIGNATURE);
      end else if (b == 0) begin
        fail_parse(ERR_NO_MEMBERS);
      end else begin
        ph = PH_REC;
      end
    end
    if (ph == PH_REC) begin
      if (mcount > max_mem) begin
        fail_parse(ERR_TOO_MANY);
      end else if (b == 0) begin
        ph = PH_DONE;
        add_result(KIND_COMPLETE, 9, p + 40'd1);
      end else begin
        rec_start = p;
        fcount = b;
        clen = 0;
        cdots = 1'b1;
        pend_bad = 1'b0;
        pend_path = 1'b0;
        ph = PH_NAME;
      end
    end else if (ph == PH_NAME) begin
      m = (b == 8'h5C) ? 8'h2F : b;
      if (b < 8'h20 || b > 8'h7E) pend_bad = 1'b1;
      add_result(KIND_NAME_CHAR, 1, {32'd0, m});
      if (m == 8'h2F) begin
        if (comp_bad()) pend_path = 1'b1;
        clen = 0;
        cdots = 1'b1;
      end else begin
        if (clen < 3) clen++;
        if (m != 8'h2E) cdots = 1'b0;
      end
      fcount--;
      if (fcount == 0) begin
        if (clen != 0 && comp_bad()) pend_path = 1'b1;
        if (pend_bad) fail_parse(ERR_NAME_CHAR);
        else if (pend_path) fail_parse(ERR_PATH);
        else ph = PH_EXTLEN;
      end
    end else if (ph == PH_EXTLEN) begin
      pend_bad = 1'b0;
      fcount = b;
      ph = (b == 0) ? PH_FIXED : PH_EXT;
    end else if (ph == PH_EXT) begin
      if (b < 8'h20 || b > 8'h7E) pend_bad = 1'b1;
      fcount--;
      if (fcount == 0) begin
        if (pend_bad) fail_parse(ERR_EXTRA_CHAR);
        else ph = PH_FIXED;
      end
    end else if (ph == PH_FIXED) begin
      if (fcount < 13) fx[fcount] = b;
      fcount++;
      if (fcount >= 13) begin
        unc = le32(5);
        comp = le32(9);
        if (unc[31] || comp[31]) fail_parse(ERR_NEG_SIZE);
        else if ((fx[0] & 8'h18) != 0) fail_parse(ERR_DIR_VOLUME);
        else if (comp == 0 && unc != 0) fail_parse(ERR_EMPTY_SIZE);
        else if (comp == 0) add_member(p + 40'd1);
        else begin
          skip_left = comp;
          fcount = 0;
          pend_bad = 1'b0;
          ph = PH_PAYLOAD;
        end
      end
    end else if (ph == PH_PAYLOAD) begin
      if (fcount < 4) begin
        ok = (fcount == 0 && b == 8'hB5) || (fcount == 1 && b == 8'h9C) ||
             (fcount == 2 && b <= 8'h01) || (fcount == 3 && b == 8'hFF);
        if (!ok) pend_bad = 1'b1;
        fcount++;
      end
      skip_left--;
      if (skip_left == 0) begin
        comp = le32(9);
        if (pend_bad || comp < 4) fail_parse(ERR_STREAM_PREFIX);
        else add_member(p + 40'd1 - {8'd0, comp});
      end
    end
    if (it.fin && ph != PH_DONE && ph != PH_ERR) begin
      if (ph == PH_REC && mcount > max_mem) fail_parse(ERR_TOO_MANY);
      else fail_parse(ERR_TRUNCATED);
    end
  endfunction

  function automatic void check_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, fname, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    parse_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, kind %0d, actual code %0d", $time, kind, error_code);
        err_cnt++;
      end else begin
        e = expected_q.pop_front();
        check_field("kind", 64'(e.kind), 64'(kind));
        check_field("name_char", 64'(e.name_char), 64'(name_char));
        check_field("rec_offset", 64'(e.rec_offset), 64'(rec_offset));
        check_field("rec_hdr_len", 64'(e.rec_hdr_len), 64'(rec_hdr_len));
        check_field("payload_offset", 64'(e.payload_offset), 64'(payload_offset));
        check_field("stored_len", 64'(e.stored_len), 64'(stored_len));
        check_field("plain_len", 64'(e.plain_len), 64'(plain_len));
        check_field("is_empty", 64'(e.is_empty), 64'(is_empty));
        check_field("dos_timestamp", 64'(e.dos_timestamp), 64'(dos_timestamp));
        check_field("arc_total", 64'(e.arc_total), 64'(arc_total));
        check_field("error_code", 64'(e.error_code), 64'(error_code));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb_archive_record_chain_parser_core: done, errors");
        $finish;
      end
    end
  end

  task automatic send_byte(arc_byte_t it, bit chk, logic [1:0] ek, logic [39:0] ev);
    int n0;
    parse_result_t r;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= it.data;
    first_byte <= it.first;
    final_byte <= it.fin;
    do @(posedge clk); while (!in_ready);
    n0 = expected_q.size();
    parse_byte(it);
    items_sent++;
    if (chk) begin
      r = expected_q[$];
      if (expected_q.size() == n0 || r.kind !== ek ||
          (ek == KIND_ERROR && r.error_code !== ev[3:0]) ||
          (ek == KIND_COMPLETE && r.arc_total !== ev)) begin
        $display("%0t: table row mismatch: expected kind %0d value %0h, actual kind %0d",
                 $time, ek, ev, r.kind);
        err_cnt++;
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BASE_OFFSET) base_off = val;
    else if (idx == REG_MAX_MEMBERS) max_mem = val[16:0];
  endtask

  function automatic bit rare(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    arc_q.push_back('{data: b, first: 1'b0, fin: 1'b0});
  endfunction

  function automatic logic [7:0] bad_char();
    return $urandom_range(1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(127, 255));
  endfunction

  function automatic void build_record();
    logic [7:0] nm[$];
    logic [31:0] comp;
    logic [31:0] unc;
    int n;
    int len;
    int r;
    if (rare(2)) begin
      len = $urandom_range(200, 255);
      repeat (len) nm.push_back(8'($urandom_range(8'h61, 8'h7A)));
    end else begin
      if (rare(3)) nm.push_back(8'h2F);
      n = $urandom_range(1, 3);
      for (int c = 0; c < n; c++) begin
        if (c > 0) nm.push_back($urandom_range(1) ? 8'h2F : 8'h5C);
        r = $urandom_range(99);
        if (r < 3) begin
        end else if (r < 6) begin
          nm.push_back(8'h2E);
        end else if (r < 9) begin
          nm.push_back(8'h2E);
          nm.push_back(8'h2E);
        end else begin
          repeat ($urandom_range(1, 4))
            nm.push_back(rare(10) ? 8'h2E : 8'($urandom_range(8'h20, 8'h7E)));
        end
      end
      if (rare(5)) nm.push_back(8'h5C);
    end
    if (nm.size() == 0) nm.push_back(8'h78);
    if (rare(5)) nm[$urandom_range(nm.size() - 1)] = bad_char();
    put_byte(8'(nm.size()));
    foreach (nm[i]) put_byte(nm[i]);
    len = $urandom_range(0, 3);
    put_byte(8'(len));
    repeat (len) put_byte(rare(4) ? bad_char() : 8'($urandom_range(8'h20, 8'h7E)));
    r = $urandom_range(99);
    if (r < 25) comp = 0;
    else if (r < 30) comp = $urandom_range(1, 3);
    else comp = $urandom_range(4, 12);
    unc = $urandom() & 32'h7FFF_FFFF;
    if (comp == 0 && !rare(10)) unc = 0;
    if (rare(3)) unc[31] = 1'b1;
    if (rare(3)) comp[31] = 1'b1;
    put_byte(rare(5) ? 8'($urandom()) : (8'($urandom()) & 8'hE7));
    repeat (4) put_byte(8'($urandom()));
    for (int i = 0; i < 4; i++) put_byte(unc[8*i +: 8]);
    for (int i = 0; i < 4; i++) put_byte(comp[8*i +: 8]);
    if (!comp[31]) begin
      for (int i = 0; i < comp; i++) begin
        case (i)
          0: put_byte(8'hB5);
          1: put_byte(8'h9C);
          2: put_byte(8'($urandom_range(1)));
          3: put_byte(8'hFF);
          default: put_byte(8'($urandom()));
        endcase
      end
      if (comp != 0 && rare(5)) arc_q[$ - $urandom_range(comp - 1)].data = 8'($urandom());
    end
  endfunction

  function automatic void build_archive();
    int cut;
    arc_q.delete();
    put_byte(8'h4B);
    put_byte(8'h4A);
    put_byte(8'h64);
    put_byte(8'h00);
    if (rare(3)) arc_q[$urandom_range(3)].data = 8'($urandom());
    repeat ($urandom_range(0, 4)) build_record();
    put_byte(8'h00);
    if (rare(5)) arc_q[$urandom_range(arc_q.size() - 1)].data = 8'($urandom());
    if (rare(8)) begin
      cut = $urandom_range(arc_q.size() - 1);
      while (arc_q.size() > cut + 1) void'(arc_q.pop_back());
    end
    arc_q[0].first = 1'b1;
    arc_q[$].fin = 1'b1;
    if (rare(10)) repeat ($urandom_range(1, 3))
      arc_q.push_back(arc_byte_t'(10'($urandom())));
    if (rare(3)) arc_q[$urandom_range(arc_q.size() - 1)] = arc_byte_t'(10'($urandom()));
  endfunction

  function automatic void add_row(logic [7:0] d, bit f, bit l, bit chk = 1'b0,
                                  logic [1:0] ek = KIND_NAME_CHAR, logic [39:0] ev = '0);
    dir_tab.push_back('{b: '{data: d, first: f, fin: l}, chk: chk, kind: ek, val: ev});
  endfunction

  initial begin
    int target;
    base_off = '0;
    max_mem = MAXM_RESET;
    clear_parse();

    add_row(8'h4B, 1'b1, 1'b0);
    add_row(8'h4A, 1'b0, 1'b0);
    add_row(8'h64, 1'b0, 1'b0);
    add_row(8'h00, 1'b0, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 1'b1, KIND_ERROR, 40'(ERR_NO_MEMBERS));
    add_row(8'h00, 1'b1, 1'b1, 1'b1, KIND_ERROR, 40'(ERR_TRUNCATED));
    add_row(8'h4B, 1'b1, 1'b0);
    add_row(8'h4A, 1'b0, 1'b0);
    add_row(8'h64, 1'b0, 1'b0);
    add_row(8'h00, 1'b0, 1'b0);
    add_row(8'h01, 1'b0, 1'b0);
    add_row(8'h61, 1'b0, 1'b0);
    add_row(8'h00, 1'b0, 1'b0);
    for (int i = 0; i < 13; i++) add_row(8'h00, 1'b0, 1'b0);
    add_row(8'h00, 1'b0, 1'b1, 1'b1, KIND_COMPLETE, 40'd21);
    add_row(8'hFF, 1'b0, 1'b1);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) send_byte(dir_tab[i].b, dir_tab[i].chk, dir_tab[i].kind, dir_tab[i].val);
    drain_results();

    for (int phase_i = 0; phase_i < 3; phase_i++) begin
      case (phase_i)
        0: begin
          snd_idle = 27;
          rcv_idle = 60;
          write_reg(REG_BASE_OFFSET, 40'hFF_FFFF_FFF0);
          write_reg(REG_MAX_MEMBERS, 40'd1);
        end
        1: begin
          snd_idle = 60;
          rcv_idle = 27;
          write_reg(REG_BASE_OFFSET, {$urandom(), 8'($urandom())});
          write_reg(REG_MAX_MEMBERS, 40'd100000);
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
          write_reg(REG_BASE_OFFSET, 40'hFF_FFFF_FFFF);
          write_reg(REG_MAX_MEMBERS, 40'd3);
        end
      endcase
      target = items_sent + 680;
      while (items_sent < target) begin
        build_archive();
        foreach (arc_q[i]) send_byte(arc_q[i], 1'b0, KIND_NAME_CHAR, '0);
        if (rare(5)) drain_results();
      end
      drain_results();
    end

    if (err_cnt == 0) begin
      $display("tb_archive_record_chain_parser_core: done, clean");
    end else begin
      $display("tb_archive_record_chain_parser_core: done, errors");
    end
    $finish;
  end

endmodule
